// ----- hdl/ibtd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibtd_pkg
// Shared widths, field codes and types of the indirect branch target decoder.
// ----------------------------------------------------------------------------
package ibtd_pkg;

  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned DISP_W    = 32;
  localparam int unsigned NUM_REGS  = 8;
  localparam int unsigned REG_IDX_W = 3;
  localparam int unsigned LEN_W     = 3;
  localparam int unsigned KIND_W    = 2;

  // input action codes
  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_DECODE = 1'b1;

  // modrm mod field
  localparam logic [1:0] MOD_NO_DISP = 2'd0;
  localparam logic [1:0] MOD_DISP8   = 2'd1;
  localparam logic [1:0] MOD_DISP32  = 2'd2;
  localparam logic [1:0] MOD_REG     = 2'd3;

  // special rm / sib codes
  localparam logic [2:0] RM_SIB       = 3'd4;
  localparam logic [2:0] RM_DISP_ONLY = 3'd5;
  localparam logic [2:0] SIB_NO_INDEX = 3'd4;
  localparam logic [2:0] SIB_NO_BASE  = 3'd5;

  // opcode extension in the modrm reg field
  localparam logic [2:0] EXT_CALL_NEAR = 3'd2;
  localparam logic [2:0] EXT_CALL_FAR  = 3'd3;
  localparam logic [2:0] EXT_JMP_NEAR  = 3'd4;
  localparam logic [2:0] EXT_JMP_FAR   = 3'd5;

  // instruction length pieces
  localparam logic [LEN_W-1:0] LEN_BASE   = 3'd2;
  localparam logic [LEN_W-1:0] LEN_DISP8  = 3'd1;
  localparam logic [LEN_W-1:0] LEN_DISP32 = 3'd4;

  // ip-relative form measures from the end of a six byte instruction
  localparam logic [ADDR_W-1:0] IP_REL_BIAS = 32'd6;

  typedef enum logic [KIND_W-1:0] {
    KIND_CALL  = 2'd0,
    KIND_JUMP  = 2'd1,
    KIND_OTHER = 2'd2
  } branch_kind_e;

endpackage

// ----- hdl/ibtd_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibtd_in_if
// Input channel: register writes and branch decode requests.
// ----------------------------------------------------------------------------
interface ibtd_in_if;
  import ibtd_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 action;
  logic [REG_IDX_W-1:0] reg_index;
  logic [ADDR_W-1:0]    reg_value;
  logic [7:0]           modrm_byte;
  logic [7:0]           sib_byte;
  logic [DISP_W-1:0]    disp_bytes;
  logic [ADDR_W-1:0]    instr_addr;

  modport source (
    output valid, action, reg_index, reg_value, modrm_byte, sib_byte, disp_bytes,
           instr_addr,
    input  ready
  );

  modport sink (
    input  valid, action, reg_index, reg_value, modrm_byte, sib_byte, disp_bytes,
           instr_addr,
    output ready
  );

endinterface

// ----- hdl/ibtd_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibtd_out_if
// Output channel: decoded branch target, length and return address.
// ----------------------------------------------------------------------------
interface ibtd_out_if;
  import ibtd_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] target;
  logic              needs_load;
  logic [KIND_W-1:0] branch_kind;
  logic [LEN_W-1:0]  instr_length;
  logic [ADDR_W-1:0] return_address;

  modport source (
    output valid, target, needs_load, branch_kind, instr_length, return_address,
    input  ready
  );

  modport sink (
    input  valid, target, needs_load, branch_kind, instr_length, return_address,
    output ready
  );

endinterface

// ----- hdl/ibtd_cfg_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibtd_cfg_if
// Configuration write channel carrying the ip-relative mode bit.
// ----------------------------------------------------------------------------
interface ibtd_cfg_if;

  logic valid;
  logic ready;
  logic ip_relative_mode;

  modport source (
    output valid, ip_relative_mode,
    input  ready
  );

  modport sink (
    input  valid, ip_relative_mode,
    output ready
  );

endinterface

// ----- hdl/ibtd_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibtd_ram
// Generic RAM, one write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
module ibtd_ram #(
  parameter  int unsigned WIDTH = 32,
  parameter  int unsigned DEPTH = 8,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ----- hdl/indirect_branch_target_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indirect_branch_target_decoder
// Pipeline: a decode passes the input register and register file read,
// then the address adder, then the result register.
// Throughput: one register write or decode per cycle unless out_o stalls.
// Reset: clears ip_relative_mode, pipeline valids and the register file
// valid bits, so every register reads as zero until written.
// ----------------------------------------------------------------------------
module indirect_branch_target_decoder (
  input  logic clk_i,
  input  logic rst_ni,
  ibtd_in_if.sink    in_i,
  ibtd_cfg_if.sink   cfg_i,
  ibtd_out_if.source out_o
);
  import ibtd_pkg::*;

  // configuration
  logic ip_rel_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ip_rel_q <= 1'b0;
    end else if (cfg_i.valid) begin
      ip_rel_q <= cfg_i.ip_relative_mode;
    end
  end

  // handshake and pipeline control
  logic in_acc;
  logic is_wr;
  logic is_dec;
  logic out_free;
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic s1_adv;

  assign out_free    = !out_valid_q || out_o.ready;
  assign s1_adv      = s1_valid_q && out_free;
  assign in_i.ready  = !s1_valid_q || out_free;
  assign in_acc      = in_i.valid && in_i.ready;
  assign is_wr       = in_acc && (in_i.action == ACT_WRITE);
  assign is_dec      = in_acc && (in_i.action == ACT_DECODE);

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = is_dec;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // register file: valid bits make unwritten registers read as zero
  logic [NUM_REGS-1:0]  reg_vld_q;
  logic [REG_IDX_W-1:0] raddr_a;
  logic [REG_IDX_W-1:0] raddr_b;
  logic [ADDR_W-1:0]    rdata_a;
  logic [ADDR_W-1:0]    rdata_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_vld_q <= '0;
    end else if (is_wr) begin
      reg_vld_q[in_i.reg_index] <= 1'b1;
    end
  end

  // port a is the base (sib base or rm), port b the sib index
  always_comb begin
    raddr_a = in_i.modrm_byte[2:0];
    if ((in_i.modrm_byte[7:6] != MOD_REG) && (in_i.modrm_byte[2:0] == RM_SIB)) begin
      raddr_a = in_i.sib_byte[2:0];
    end
    raddr_b = in_i.sib_byte[5:3];
  end

  ibtd_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (NUM_REGS)
  ) u_regfile (
    .clk_i     (clk_i),
    .we_i      (is_wr),
    .waddr_i   (in_i.reg_index),
    .wdata_i   (in_i.reg_value),
    .re_i      (is_dec),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // input register for the decode fields
  logic [7:0]        s1_modrm_q;
  logic [7:0]        s1_sib_q;
  logic [DISP_W-1:0] s1_disp_q;
  logic [ADDR_W-1:0] s1_ia_q;
  logic              s1_a_vld_q;
  logic              s1_b_vld_q;

  always_ff @(posedge clk_i) begin
    if (is_dec) begin
      s1_modrm_q <= in_i.modrm_byte;
      s1_sib_q   <= in_i.sib_byte;
      s1_disp_q  <= in_i.disp_bytes;
      s1_ia_q    <= in_i.instr_addr;
      s1_a_vld_q <= reg_vld_q[raddr_a];
      s1_b_vld_q <= reg_vld_q[raddr_b];
    end
  end

  // address decode
  logic [1:0]        dmod;
  logic [2:0]        dreg;
  logic [2:0]        drm;
  logic [1:0]        scale;
  logic [2:0]        sidx;
  logic [2:0]        sbase;
  logic              has_sib;
  logic [ADDR_W-1:0] reg_a;
  logic [ADDR_W-1:0] reg_b;
  logic [ADDR_W-1:0] index_term;
  logic [ADDR_W-1:0] base_term;
  logic [ADDR_W-1:0] disp_term;
  logic [ADDR_W-1:0] disp8_sx;
  logic [LEN_W-1:0]  len;
  logic [ADDR_W-1:0] target;
  branch_kind_e      kind;
  logic [ADDR_W-1:0] ret_addr;

  assign dmod     = s1_modrm_q[7:6];
  assign dreg     = s1_modrm_q[5:3];
  assign drm      = s1_modrm_q[2:0];
  assign scale    = s1_sib_q[7:6];
  assign sidx     = s1_sib_q[5:3];
  assign sbase    = s1_sib_q[2:0];
  assign has_sib  = (dmod != MOD_REG) && (drm == RM_SIB);
  assign reg_a    = s1_a_vld_q ? rdata_a : '0;
  assign reg_b    = s1_b_vld_q ? rdata_b : '0;
  assign disp8_sx = {{(ADDR_W-8){s1_disp_q[7]}}, s1_disp_q[7:0]};

  always_comb begin
    index_term = '0;
    base_term  = reg_a;
    len        = LEN_BASE;
    if (has_sib) begin
      len = LEN_BASE + LEN_DISP8;
      if (sidx != SIB_NO_INDEX) begin
        index_term = reg_b << scale;
      end
      if ((sbase == SIB_NO_BASE) && (dmod == MOD_NO_DISP)) begin
        base_term = s1_disp_q;
        len       = len + LEN_DISP32;
      end
    end else if ((dmod == MOD_NO_DISP) && (drm == RM_DISP_ONLY)) begin
      base_term = s1_disp_q;
      len       = LEN_BASE + LEN_DISP32;
      if (ip_rel_q) begin
        index_term = s1_ia_q + IP_REL_BIAS;
      end
    end

    unique case (dmod)
      MOD_DISP8: begin
        disp_term = disp8_sx;
        len       = len + LEN_DISP8;
      end
      MOD_DISP32: begin
        disp_term = s1_disp_q;
        len       = len + LEN_DISP32;
      end
      default: begin
        disp_term = '0;
      end
    endcase

    target = index_term + base_term + disp_term;
  end

  always_comb begin
    unique case (dreg)
      EXT_CALL_NEAR, EXT_CALL_FAR: kind = KIND_CALL;
      EXT_JMP_NEAR, EXT_JMP_FAR:   kind = KIND_JUMP;
      default:                     kind = KIND_OTHER;
    endcase
    ret_addr = (kind == KIND_CALL) ? (s1_ia_q + ADDR_W'(len)) : '0;
  end

  // result register
  logic [ADDR_W-1:0] out_target_q;
  logic              out_load_q;
  logic [KIND_W-1:0] out_kind_q;
  logic [LEN_W-1:0]  out_len_q;
  logic [ADDR_W-1:0] out_ret_q;

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_target_q <= target;
      out_load_q   <= (dmod != MOD_REG);
      out_kind_q   <= kind;
      out_len_q    <= len;
      out_ret_q    <= ret_addr;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.target         = out_target_q;
  assign out_o.needs_load     = out_load_q;
  assign out_o.branch_kind    = out_kind_q;
  assign out_o.instr_length   = out_len_q;
  assign out_o.return_address = out_ret_q;

  // checks
  a_dec_enters_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_dec |=> s1_valid_q)
    else $error("accepted decode did not reach the input register");

  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_wr |=> !s1_valid_q)
    else $error("register write produced a decode in flight");

  a_write_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_wr |=> reg_vld_q[$past(in_i.reg_index)])
    else $error("register write did not mark its entry valid");

  a_ret_only_calls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_kind_q != KIND_CALL) |-> (out_ret_q == '0))
    else $error("return address set for a non-call result");

endmodule
